[src/assert_macros.svh]
// assertion macros included by the image resize sampler
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/irs_pkg.sv]
// constants and register codes for the image resize sampler
// no dependencies
package irs_pkg;

    localparam int MAX_WIDTH_DEF    = 512;
    localparam int MAX_HEIGHT_DEF   = 512;
    localparam int MAX_CHANNELS_DEF = 4;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int POS_W    = 10;
    localparam int CHAN_W   = 2;
    localparam int SAMPLE_W = 8;
    localparam int DIM_W    = 10;
    localparam int NCH_W    = 3;
    localparam int STEP_W   = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 26;
    localparam int CMP_W    = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP       = 3'd5;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    localparam logic MODE_NEAREST  = 1'b0;
    localparam logic MODE_BILINEAR = 1'b1;

    localparam logic [DIM_W-1:0]  SRC_WIDTH_RST    = 10'd512;
    localparam logic [DIM_W-1:0]  SRC_HEIGHT_RST   = 10'd512;
    localparam logic [NCH_W-1:0]  NUM_CHANNELS_RST = 3'd3;
    localparam logic              INTERP_MODE_RST  = MODE_BILINEAR;
    localparam logic [STEP_W-1:0] STEP_RST         = 26'd65536;

endpackage

[src/irs_req_if.sv]
// request channel of the image resize sampler: write and sample request beats
// uses irs_pkg widths
interface irs_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [irs_pkg::POS_W-1:0]     pos_x;
    logic [irs_pkg::POS_W-1:0]     pos_y;
    logic [irs_pkg::CHAN_W-1:0]    chan;
    logic [irs_pkg::SAMPLE_W-1:0]  sample_in;

    modport source (output valid, func, pos_x, pos_y, chan, sample_in, input ready);
    modport sink   (input valid, func, pos_x, pos_y, chan, sample_in, output ready);
endinterface

[src/irs_rsp_if.sv]
// response channel of the image resize sampler
// uses irs_pkg widths
interface irs_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [irs_pkg::SAMPLE_W-1:0]  sample_out;
    logic                          range_error;

    modport source (output valid, sample_out, range_error, input ready);
    modport sink   (input valid, sample_out, range_error, output ready);
endinterface

[src/irs_ram.sv]
// generic single-port ram with registered read and a clock enable
// no dependencies
module irs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;
endmodule

[src/image_resize_sampler.sv]
// image resize sampler: a request beat passes stages 1 to 4 and then the response register
// throughput one beat per cycle; four frame banks split by column and row parity
// serve all four neighbours in the same cycle, a stalled response freezes the pipeline
// synchronous active-low reset restores the register defaults and empties the
// pipeline; the frame store is not cleared
module image_resize_sampler #(
    parameter int MAX_WIDTH    = irs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = irs_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_CHANNELS = irs_pkg::MAX_CHANNELS_DEF,
    parameter int FRAC_BITS    = irs_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [irs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [irs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    irs_req_if.sink                            i_req,
    irs_rsp_if.source                          o_rsp
);
    `include "assert_macros.svh"

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int XHW = (XW > 1) ? XW - 1 : 1;
    localparam int YHW = (YW > 1) ? YW - 1 : 1;
    localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int AW  = YHW + XHW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int SXW = irs_pkg::POS_W + irs_pkg::STEP_W;
    localparam int FW  = FRAC_BITS + 1;
    localparam int HW  = irs_pkg::SAMPLE_W + FRAC_BITS + 1;
    localparam int SW  = irs_pkg::SAMPLE_W + 2 * FRAC_BITS + 1;
    localparam int RW  = SW + 1 - 2 * FRAC_BITS;
    localparam int DW  = irs_pkg::CMP_W;

    // configuration registers
    logic [irs_pkg::DIM_W-1:0]  r_src_width, r_src_height;
    logic [irs_pkg::NCH_W-1:0]  r_num_channels;
    logic                       r_interp_mode;
    logic [irs_pkg::STEP_W-1:0] r_x_step, r_y_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width    <= irs_pkg::SRC_WIDTH_RST;
            r_src_height   <= irs_pkg::SRC_HEIGHT_RST;
            r_num_channels <= irs_pkg::NUM_CHANNELS_RST;
            r_interp_mode  <= irs_pkg::INTERP_MODE_RST;
            r_x_step       <= irs_pkg::STEP_RST;
            r_y_step       <= irs_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                irs_pkg::CFG_SRC_WIDTH:    r_src_width <= i_cfg_data[irs_pkg::DIM_W-1:0];
                irs_pkg::CFG_SRC_HEIGHT:   r_src_height <= i_cfg_data[irs_pkg::DIM_W-1:0];
                irs_pkg::CFG_NUM_CHANNELS: r_num_channels <= i_cfg_data[irs_pkg::NCH_W-1:0];
                irs_pkg::CFG_INTERP_MODE:  r_interp_mode <= i_cfg_data[0];
                irs_pkg::CFG_X_STEP:       r_x_step <= i_cfg_data;
                irs_pkg::CFG_Y_STEP:       r_y_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes, saturated to 1..MAX
    logic [DW-1:0] w_eff, h_eff, nc_eff, w_m1, h_m1;
    always_comb begin
        if (r_src_width == '0) w_eff = DW'(1);
        else if (DW'(r_src_width) > DW'(MAX_WIDTH)) w_eff = DW'(MAX_WIDTH);
        else w_eff = DW'(r_src_width);
        if (r_src_height == '0) h_eff = DW'(1);
        else if (DW'(r_src_height) > DW'(MAX_HEIGHT)) h_eff = DW'(MAX_HEIGHT);
        else h_eff = DW'(r_src_height);
        if (r_num_channels == '0) nc_eff = DW'(1);
        else if (DW'(r_num_channels) > DW'(MAX_CHANNELS)) nc_eff = DW'(MAX_CHANNELS);
        else nc_eff = DW'(r_num_channels);
        w_m1 = w_eff - DW'(1);
        h_m1 = h_eff - DW'(1);
    end

    // global advance: the whole pipeline moves unless the response is stalled
    logic r_out_valid;
    logic en;
    assign en = !r_out_valid || o_rsp.ready;
    assign i_req.ready = en;

    logic accept;
    assign accept = i_req.valid && en;

    logic in_err;
    always_comb begin
        if (i_req.func == irs_pkg::FUNC_WRITE) begin
            in_err = (DW'(i_req.pos_x) >= w_eff) || (DW'(i_req.pos_y) >= h_eff)
                  || (DW'(i_req.chan) >= nc_eff);
        end else begin
            in_err = DW'(i_req.chan) >= nc_eff;
        end
    end

    // stage 1: source coordinates
    logic                          r1_v, r1_func, r1_err;
    logic [irs_pkg::POS_W-1:0]     r1_px, r1_py;
    logic [irs_pkg::CHAN_W-1:0]    r1_ch;
    logic [irs_pkg::SAMPLE_W-1:0]  r1_val;
    logic [SXW-1:0]                r1_sx, r1_sy;
    logic                          r1_near;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_func <= i_req.func;
            r1_err  <= in_err;
            r1_px   <= i_req.pos_x;
            r1_py   <= i_req.pos_y;
            r1_ch   <= i_req.chan;
            r1_val  <= i_req.sample_in;
            r1_sx   <= SXW'(i_req.pos_x) * SXW'(r_x_step);
            r1_sy   <= SXW'(i_req.pos_y) * SXW'(r_y_step);
            r1_near <= r_interp_mode == irs_pkg::MODE_NEAREST;
        end
    end

    // clamp to the image and find the right and lower neighbours
    logic [DW-1:0]  sx_int, sy_int;
    logic [XW-1:0]  x1, x2;
    logic [YW-1:0]  y1, y2;
    logic           xdup, ydup;
    logic [XHW-1:0] col_even, col_odd;
    logic [YHW-1:0] row_even, row_odd;
    logic [CW-1:0]  ch_a;
    logic [FRAC_BITS-1:0] fx, fy;
    logic           wr_ok;

    always_comb begin
        sx_int = DW'(r1_sx >> FRAC_BITS);
        sy_int = DW'(r1_sy >> FRAC_BITS);
        x1 = (sx_int > w_m1) ? XW'(w_m1) : XW'(sx_int);
        y1 = (sy_int > h_m1) ? YW'(h_m1) : YW'(sy_int);
        xdup = DW'(x1) == w_m1;
        ydup = DW'(y1) == h_m1;
        x2 = xdup ? x1 : x1 + XW'(1);
        y2 = ydup ? y1 : y1 + YW'(1);
        col_even = x1[0] ? XHW'(x2 >> 1) : XHW'(x1 >> 1);
        col_odd  = x1[0] ? XHW'(x1 >> 1) : XHW'(x2 >> 1);
        row_even = y1[0] ? YHW'(y2 >> 1) : YHW'(y1 >> 1);
        row_odd  = y1[0] ? YHW'(y1 >> 1) : YHW'(y2 >> 1);
        ch_a = CW'(r1_ch);
        fx = r1_near ? '0 : r1_sx[FRAC_BITS-1:0];
        fy = r1_near ? '0 : r1_sy[FRAC_BITS-1:0];
        wr_ok = r1_v && (r1_func == irs_pkg::FUNC_WRITE) && !r1_err;
    end

    // four frame banks, bank index is {row parity, column parity}
    logic [XW-1:0] wx;
    logic [YW-1:0] wy;
    logic [1:0]    wbank;
    assign wx = XW'(r1_px);
    assign wy = YW'(r1_py);
    assign wbank = {wy[0], wx[0]};

    logic [irs_pkg::SAMPLE_W-1:0] bank_q [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [AW-1:0] addr;
        logic          we;
        always_comb begin
            we = wr_ok && (wbank == 2'(b));
            if (we) begin
                addr = {YHW'(wy >> 1), XHW'(wx >> 1), ch_a};
            end else begin
                addr = {(b / 2 == 1) ? row_odd : row_even,
                        (b % 2 == 1) ? col_odd : col_even, ch_a};
            end
        end
        irs_ram #(
            .WIDTH (irs_pkg::SAMPLE_W),
            .DEPTH (DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_we    (we),
            .i_addr  (addr),
            .i_wdata (r1_val),
            .o_rdata (bank_q[b])
        );
    end

    // stage 2: bank data arrives, horizontal blend
    logic                 r2_v, r2_zero, r2_err, r2_x1p, r2_xd, r2_y1p, r2_yd, r2_near;
    logic [FRAC_BITS-1:0] r2_fx, r2_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_err  <= r1_err;
            r2_zero <= r1_err || (r1_func == irs_pkg::FUNC_WRITE);
            r2_x1p  <= x1[0];
            r2_xd   <= xdup;
            r2_y1p  <= y1[0];
            r2_yd   <= ydup;
            r2_near <= r1_near;
            r2_fx   <= fx;
            r2_fy   <= fy;
        end
    end

    logic       xr, yr;
    logic [FW-1:0] wfx, wfx_n;
    logic [HW-1:0] n_top, n_bot;
    always_comb begin
        xr = r2_xd ? r2_x1p : !r2_x1p;
        yr = r2_yd ? r2_y1p : !r2_y1p;
        wfx   = FW'(r2_fx);
        wfx_n = FW'(1 << FRAC_BITS) - wfx;
        if (r2_near) begin
            // nearest uses only the upper-left sample, other banks may hold no data
            n_top = HW'(bank_q[{r2_y1p, r2_x1p}]) << FRAC_BITS;
            n_bot = n_top;
        end else begin
            n_top = HW'(bank_q[{r2_y1p, r2_x1p}]) * HW'(wfx_n)
                  + HW'(bank_q[{r2_y1p, xr}]) * HW'(wfx);
            n_bot = HW'(bank_q[{yr, r2_x1p}]) * HW'(wfx_n)
                  + HW'(bank_q[{yr, xr}]) * HW'(wfx);
        end
    end

    // stage 3: vertical blend
    logic                 r3_v, r3_zero, r3_err;
    logic [HW-1:0]        r3_top, r3_bot;
    logic [FRAC_BITS-1:0] r3_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_zero <= r2_zero;
            r3_err  <= r2_err;
            r3_top  <= n_top;
            r3_bot  <= n_bot;
            r3_fy   <= r2_fy;
        end
    end

    logic [FW-1:0] wfy, wfy_n;
    logic [SW-1:0] n_sum;
    always_comb begin
        wfy   = FW'(r3_fy);
        wfy_n = FW'(1 << FRAC_BITS) - wfy;
        n_sum = SW'(r3_top) * SW'(wfy_n) + SW'(r3_bot) * SW'(wfy);
    end

    // stage 4: exact sum
    logic          r4_v, r4_zero, r4_err;
    logic [SW-1:0] r4_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_zero <= r3_zero;
            r4_err  <= r3_err;
            r4_sum  <= n_sum;
        end
    end

    // round half up and saturate; writes and error beats give zero
    logic [SW:0]   rounded;
    logic [RW-1:0] rq;
    logic [irs_pkg::SAMPLE_W-1:0] n_sample;
    always_comb begin
        rounded = (SW + 1)'(r4_sum) + ((SW + 1)'(1) << (2 * FRAC_BITS - 1));
        rq = RW'(rounded >> (2 * FRAC_BITS));
        if (r4_zero) n_sample = '0;
        else if (rq > RW'(255)) n_sample = '1;
        else n_sample = irs_pkg::SAMPLE_W'(rq);
    end

    // response register
    logic [irs_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                         r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_sample <= n_sample;
            r_out_err    <= r4_err;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.sample_out  = r_out_sample;
    assign o_rsp.range_error = r_out_err;

    `ASSERT_NOW(a_err_zero, i_clk, i_rst_n, r_out_valid && r_out_err, r_out_sample == '0, "error beat carries a nonzero sample")
    `ASSERT_NOW(a_stall_only_on_out, i_clk, i_rst_n, !i_req.ready, r_out_valid && !o_rsp.ready, "request stalled without output backpressure")
    `ASSERT_NEXT(a_s4_to_out, i_clk, i_rst_n, en && r4_v, r_out_valid, "stage four beat lost before response")
    `ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, !en, r4_v == $past(r4_v) && r1_v == $past(r1_v), "pipeline moved during stall")

endmodule
